// ----- hdl/hkar_pkg.sv -----
// Shared types and constants for the hotkey edge and key autorepeat unit.
package hkar_pkg;

	localparam int KeyW    = 8;
	localparam int TimeW   = 64;
	localparam int CfgW    = 32;
	localparam int CfgIdxW = 8;
	localparam int InDataW  = 80;
	localparam int OutDataW = 144;

	localparam logic [CfgIdxW-1:0] CFG_REPEAT_DELAY = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_REPEAT_RATE  = 8'd1;

	localparam logic [CfgW-1:0] DELAY_RESET = 32'd400000;
	localparam logic [CfgW-1:0] RATE_RESET  = 32'd80000;

	localparam logic REQ_SNAPSHOT = 1'b0;
	localparam logic REQ_POLL     = 1'b1;

	localparam int SC_PRTSCR = 0;
	localparam int SC_SCRLK  = 1;
	localparam int SC_UP     = 2;
	localparam int SC_LEFT   = 3;
	localparam int SC_DOWN   = 4;
	localparam int SC_RIGHT  = 5;
	localparam int SC_ENTER  = 6;
	localparam int SC_ESC    = 7;

	typedef struct packed {
		logic             req_type;
		logic [KeyW-1:0]  key_bits;
		logic             menu_on;
		logic [TimeW-1:0] now_us;
	} item_t;

	typedef struct packed {
		logic menu_request;
		logic second_display_request;
		logic kbd_routed;
		logic back_event;
		logic select_hit;
	} key_res_t;

	typedef struct packed {
		logic             pressed;
		logic             held;
		logic [TimeW-1:0] hold_start;
	} lane_res_t;

	typedef struct packed {
		key_res_t  keys;
		lane_res_t up;
		lane_res_t down;
	} result_t;

endpackage

// ----- hdl/hkar_keys.sv -----
// Hotkey edge detection, menu key levels and pending select.
module hkar_keys (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  hkar_pkg::item_t   item,
	output hkar_pkg::key_res_t res,
	output logic [1:0]        dir_levels
);
	import hkar_pkg::*;

	logic       last_prtscr_q, last_scrlk_q, last_enter_q, last_esc_q;
	logic       routed_q, select_pending_q;
	logic [1:0] dir_levels_q;
	logic       snap, prt, scr, ent, esc;
	logic [1:0] lv;

	assign snap = (item.req_type == REQ_SNAPSHOT);
	assign prt  = item.key_bits[SC_PRTSCR];
	assign scr  = item.key_bits[SC_SCRLK];
	assign ent  = item.key_bits[SC_ENTER];
	assign esc  = item.key_bits[SC_ESC];
	assign lv   = {item.key_bits[SC_DOWN] | item.key_bits[SC_RIGHT],
		item.key_bits[SC_UP] | item.key_bits[SC_LEFT]};

	always_comb begin
		res.menu_request           = snap & prt & ~last_prtscr_q;
		res.second_display_request = snap & scr & ~last_scrlk_q;
		res.kbd_routed             = snap ? item.menu_on : routed_q;
		res.back_event             = snap & item.menu_on & esc & ~last_esc_q;
		res.select_hit             = ~snap & select_pending_q;
	end

	assign dir_levels = dir_levels_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_prtscr_q    <= 1'b0;
			last_scrlk_q     <= 1'b0;
			last_enter_q     <= 1'b0;
			last_esc_q       <= 1'b0;
			routed_q         <= 1'b0;
			select_pending_q <= 1'b0;
			dir_levels_q     <= 2'b00;
		end else if (advance) begin
			if (snap) begin
				last_prtscr_q <= prt;
				last_scrlk_q  <= scr;
				last_enter_q  <= ent;
				last_esc_q    <= esc;
				routed_q      <= item.menu_on;
				dir_levels_q  <= item.menu_on ? lv : 2'b00;
				if (item.menu_on && ent && !last_enter_q) begin
					select_pending_q <= 1'b1;
				end
			end else begin
				select_pending_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/hkar_repeat.sv -----
// Typematic repeat timer for one direction key.
module hkar_repeat (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       poll,
	input  logic                       level,
	input  logic [hkar_pkg::TimeW-1:0] now_us,
	input  logic [hkar_pkg::CfgW-1:0]  delay_us,
	input  logic [hkar_pkg::CfgW-1:0]  rate_us,
	output hkar_pkg::lane_res_t        res
);
	import hkar_pkg::*;

	logic             held_q;
	logic [TimeW-1:0] begin_q, fire_q;
	logic [TimeW-1:0] dur, since;
	logic [CfgW-1:0]  wait_us;
	logic             rise, fire;

	assign rise    = level & ~held_q;
	assign dur     = now_us - begin_q;
	assign since   = now_us - fire_q;
	// first repeat waits the initial delay, later ones the repeat rate
	assign wait_us = (dur < {{(TimeW-CfgW){1'b0}}, delay_us}) ? delay_us : rate_us;
	assign fire    = poll & (rise | (level & (since >= {{(TimeW-CfgW){1'b0}}, wait_us})));

	always_comb begin
		res.pressed    = fire;
		res.held       = poll ? level : held_q;
		res.hold_start = (poll & rise) ? now_us : begin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			begin_q <= '0;
			fire_q  <= '0;
		end else if (advance && poll) begin
			held_q <= level;
			if (rise) begin
				begin_q <= now_us;
			end
			if (fire) begin
				fire_q <= now_us;
			end
		end
	end

endmodule

// ----- hdl/hotkey_edge_and_key_autorepeat_unit.sv -----
// Top level: input register, key and repeat logic, result register.
// An item passes through the input register and then the result register before
// m_tvalid rises for it.
// Throughput: one item per cycle; the input register advances whenever the
// result register is empty or being taken, so both sides run back to back.
// Reset clears all key history, hold times and the pipeline; the repeat delay
// and rate registers return to 400000 us and 80000 us.
module hotkey_edge_and_key_autorepeat_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// key_bits[7:0], menu_on[8], now_us[72:9], zero fill
	input  logic [hkar_pkg::InDataW-1:0]  s_tdata,
	// req_type
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// menu_request[0], second_display_request[1], kbd_routed[2], back_event[3],
	// select_hit[4], up_fire[5], down_fire[6], up_held[7], down_held[8],
	// up_hold_start[72:9], down_hold_start[136:73], zero fill
	output logic [hkar_pkg::OutDataW-1:0] m_tdata,
	input  logic                          cfg_we,
	input  logic [hkar_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hkar_pkg::CfgW-1:0]     cfg_data
);
	import hkar_pkg::*;

	logic [CfgW-1:0] delay_q, rate_q;
	item_t           item_s1;
	logic            valid_s1;
	result_t         result_s2;
	logic            valid_s2;
	logic            advance, poll;
	key_res_t        key_res;
	lane_res_t       up_res, down_res;
	logic [1:0]      dir_levels;

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign poll     = (item_s1.req_type == REQ_POLL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			rate_q  <= RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_REPEAT_DELAY: delay_q <= cfg_data;
				CFG_REPEAT_RATE:  rate_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type <= s_tuser;
			item_s1.key_bits <= s_tdata[KeyW-1:0];
			item_s1.menu_on  <= s_tdata[KeyW];
			item_s1.now_us   <= s_tdata[KeyW+TimeW:KeyW+1];
		end
	end

	hkar_keys u_keys (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.res        (key_res),
		.dir_levels (dir_levels)
	);

	hkar_repeat u_up (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.poll     (poll),
		.level    (dir_levels[0]),
		.now_us   (item_s1.now_us),
		.delay_us (delay_q),
		.rate_us  (rate_q),
		.res      (up_res)
	);

	hkar_repeat u_down (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.poll     (poll),
		.level    (dir_levels[1]),
		.now_us   (item_s1.now_us),
		.delay_us (delay_q),
		.rate_us  (rate_q),
		.res      (down_res)
	);

	// hold the result while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.keys <= key_res;
			result_s2.up   <= up_res;
			result_s2.down <= down_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0,
		result_s2.down.hold_start,
		result_s2.up.hold_start,
		result_s2.down.held,
		result_s2.up.held,
		result_s2.down.pressed,
		result_s2.up.pressed,
		result_s2.keys.select_hit,
		result_s2.keys.back_event,
		result_s2.keys.kbd_routed,
		result_s2.keys.second_display_request,
		result_s2.keys.menu_request};

endmodule
